// ----- rtl/mts_pkg.sv -----
`timescale 1ns / 1ps

package mts_pkg;

  localparam int DEPTH_DEFAULT      = 64;
  localparam int DATA_WIDTH_DEFAULT = 32;

  // action selector carried on in_tuser
  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_POP  = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_POP_EMPTY = 2'd1,
    STATUS_PUSH_FULL = 2'd2
  } status_t;

  typedef enum logic {
    ST_IDLE,
    ST_REFILL
  } state_t;

endpackage

// ----- rtl/mts_store.sv -----
`timescale 1ns / 1ps

module mts_store #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [$clog2(DEPTH)-1:0]     wr_addr,
  input  logic [DATA_WIDTH-1:0]        wr_data,
  input  logic                         rd_en,
  input  logic [$clog2(DEPTH)-1:0]     rd_addr,
  output logic [DATA_WIDTH-1:0]        rd_data
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/min_tracking_stack.sv -----
`timescale 1ns / 1ps

// Bounded LIFO stack that also reports the running minimum of its entries.
// Input channel (in_*): one word per operation; in_tuser selects push (0) or
// pop (1), in_tdata carries the signed value to push (ignored on a pop).
// Result channel (out_*): exactly one word per operation, in order, holding
// the popped value, the minimum after the operation, the empty flag and a
// status code (ok, pop on empty, push on full dropped).
// Both stores live in single-port-write, registered-read RAMs; the two stack
// tops are cached in registers. A push, or any rejected operation, completes
// in the accept cycle and its result shows up in the cycle after. A valid pop
// reads the next main top (and min top, if the popped value was the minimum)
// from the RAMs and waits in ST_REFILL for the read data before registering
// its result; the next word can be taken in the cycle that result is taken.
// Reset empties both stacks at once (counts cleared, no clearing pass) and
// drops any pending result. When the receiver stalls, the result holds in
// the output register and no new operation is accepted until it is taken.
module min_tracking_stack #(
  parameter int DEPTH      = mts_pkg::DEPTH_DEFAULT,
  parameter int DATA_WIDTH = mts_pkg::DATA_WIDTH_DEFAULT
) (
  input  logic                                         clk,
  input  logic                                         rst_n,
  input  logic                                         in_tvalid,
  output logic                                         in_tready,
  // [DATA_WIDTH-1:0] push_value, zero filled to whole bytes
  input  logic [((DATA_WIDTH+7)/8)*8-1:0]              in_tdata,
  // [0] action
  input  logic                                         in_tuser,
  output logic                                         out_tvalid,
  input  logic                                         out_tready,
  // [DATA_WIDTH-1:0] popped_value, [2*DATA_WIDTH-1:DATA_WIDTH] current_min,
  // [2*DATA_WIDTH] is_empty, zero filled to whole bytes
  output logic [((2*DATA_WIDTH+1+7)/8)*8-1:0]          out_tdata,
  // [1:0] status
  output logic [1:0]                                   out_tuser
);

  import mts_pkg::*;

  localparam int AW     = $clog2(DEPTH);
  localparam int CW     = $clog2(DEPTH + 1);
  localparam int OUT_TW = ((2*DATA_WIDTH+1+7)/8)*8;

  state_t state_r, state_nxt;

  logic [CW-1:0]                main_count_r, main_count_nxt;
  logic [CW-1:0]                min_count_r,  min_count_nxt;
  logic signed [DATA_WIDTH-1:0] main_top_r,   main_top_nxt;
  logic signed [DATA_WIDTH-1:0] min_top_r,    min_top_nxt;
  logic signed [DATA_WIDTH-1:0] pop_val_r,    pop_val_nxt;
  logic                         min_reload_r, min_reload_nxt;

  logic                         out_valid_r,  out_valid_nxt;
  logic signed [DATA_WIDTH-1:0] out_popped_r, out_popped_nxt;
  logic signed [DATA_WIDTH-1:0] out_min_r,    out_min_nxt;
  logic                         out_empty_r,  out_empty_nxt;
  status_t                      out_status_r, out_status_nxt;

  logic                         in_fire;
  logic signed [DATA_WIDTH-1:0] push_value;

  logic                         main_wr_en, min_wr_en;
  logic                         main_rd_en, min_rd_en;
  logic [AW-1:0]                main_wr_addr, min_wr_addr;
  logic [AW-1:0]                main_rd_addr, min_rd_addr;
  logic [DATA_WIDTH-1:0]        main_rd_data, min_rd_data;
  logic [CW-1:0]                main_rd_idx, min_rd_idx;

  // accept only when idle and the result slot is free or draining
  assign in_tready  = (state_r == ST_IDLE) && (!out_valid_r || out_tready);
  assign in_fire    = in_tvalid && in_tready;
  assign push_value = in_tdata[DATA_WIDTH-1:0];

  // RAM addresses: write at the count, read the entry below the top
  assign main_wr_addr = main_count_r[AW-1:0];
  assign min_wr_addr  = min_count_r[AW-1:0];
  assign main_rd_idx  = main_count_r - CW'(2);
  assign min_rd_idx   = min_count_r - CW'(2);
  assign main_rd_addr = main_rd_idx[AW-1:0];
  assign min_rd_addr  = min_rd_idx[AW-1:0];

  mts_store #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_main_store (
    .clk     (clk),
    .wr_en   (main_wr_en),
    .wr_addr (main_wr_addr),
    .wr_data (push_value),
    .rd_en   (main_rd_en),
    .rd_addr (main_rd_addr),
    .rd_data (main_rd_data)
  );

  mts_store #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_min_store (
    .clk     (clk),
    .wr_en   (min_wr_en),
    .wr_addr (min_wr_addr),
    .wr_data (push_value),
    .rd_en   (min_rd_en),
    .rd_addr (min_rd_addr),
    .rd_data (min_rd_data)
  );

  always_comb begin
    state_nxt      = state_r;
    main_count_nxt = main_count_r;
    min_count_nxt  = min_count_r;
    main_top_nxt   = main_top_r;
    min_top_nxt    = min_top_r;
    pop_val_nxt    = pop_val_r;
    min_reload_nxt = min_reload_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_popped_nxt = out_popped_r;
    out_min_nxt    = out_min_r;
    out_empty_nxt  = out_empty_r;
    out_status_nxt = out_status_r;
    main_wr_en     = 1'b0;
    min_wr_en      = 1'b0;
    main_rd_en     = 1'b0;
    min_rd_en      = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_tuser == ACT_POP) begin
            if (main_count_r == '0) begin
              // pop on empty: state untouched, report the error now
              out_valid_nxt  = 1'b1;
              out_popped_nxt = '0;
              out_min_nxt    = (min_count_r != '0) ? min_top_r : '0;
              out_empty_nxt  = 1'b1;
              out_status_nxt = STATUS_POP_EMPTY;
            end else begin
              // drop the main top (and the min top if it matches) and fetch the entries below
              main_count_nxt = main_count_r - CW'(1);
              pop_val_nxt    = main_top_r;
              main_rd_en     = 1'b1;
              min_reload_nxt = 1'b0;
              if ((min_count_r != '0) && (min_top_r == main_top_r)) begin
                min_count_nxt  = min_count_r - CW'(1);
                min_rd_en      = 1'b1;
                min_reload_nxt = 1'b1;
              end
              state_nxt = ST_REFILL;
            end
          end else begin
            if (main_count_r == CW'(DEPTH)) begin
              // push on full: drop the value
              out_valid_nxt  = 1'b1;
              out_popped_nxt = '0;
              out_min_nxt    = (min_count_r != '0) ? min_top_r : '0;
              out_empty_nxt  = (main_count_r == '0);
              out_status_nxt = STATUS_PUSH_FULL;
            end else begin
              main_wr_en     = 1'b1;
              main_top_nxt   = push_value;
              main_count_nxt = main_count_r + CW'(1);
              out_min_nxt    = (min_count_r != '0) ? min_top_r : '0;
              if (((min_count_r == '0) || (push_value <= min_top_r)) &&
                  (min_count_r != CW'(DEPTH))) begin
                min_wr_en     = 1'b1;
                min_top_nxt   = push_value;
                min_count_nxt = min_count_r + CW'(1);
                out_min_nxt   = push_value;
              end
              out_valid_nxt  = 1'b1;
              out_popped_nxt = '0;
              out_empty_nxt  = 1'b0;
              out_status_nxt = STATUS_OK;
            end
          end
        end
      end

      ST_REFILL: begin
        // read data is back: reload the cached main top (and min top if popped) and post the result
        if (main_count_r != '0) begin
          main_top_nxt = main_rd_data;
        end
        if (min_reload_r && (min_count_r != '0)) begin
          min_top_nxt = min_rd_data;
        end
        out_valid_nxt  = 1'b1;
        out_popped_nxt = pop_val_r;
        if (min_count_r == '0) begin
          out_min_nxt = '0;
        end else if (min_reload_r) begin
          out_min_nxt = min_rd_data;
        end else begin
          out_min_nxt = min_top_r;
        end
        out_empty_nxt  = (main_count_r == '0);
        out_status_nxt = STATUS_OK;
        state_nxt      = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      main_count_r <= '0;
      min_count_r  <= '0;
      min_reload_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      main_count_r <= main_count_nxt;
      min_count_r  <= min_count_nxt;
      min_reload_r <= min_reload_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    main_top_r   <= main_top_nxt;
    min_top_r    <= min_top_nxt;
    pop_val_r    <= pop_val_nxt;
    out_popped_r <= out_popped_nxt;
    out_min_r    <= out_min_nxt;
    out_empty_r  <= out_empty_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TW'({out_empty_r, out_min_r, out_popped_r});
  assign out_tuser  = out_status_r;

endmodule
